@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the clk_i / rst_ni pair of the enclosing module.
`define BCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The given signal keeps its value in the cycle after the condition holds.
`define BCE_ASSERT_HOLD(label, cond, sig, msg) \
  `BCE_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

@@ hw/rtl/bce_pkg.sv @@
// Package of the battery charge estimator: widths, curve table, codes and types.
`default_nettype none

package bce_pkg;

  localparam int HISTORY_DEPTH = 100;
  localparam int CURVE_POINTS  = 16;

  localparam int MV_W     = 15;
  localparam int CUR_W    = 16;
  localparam int ALPHA_W  = 17;
  localparam int PCT_W    = 7;
  localparam int FRAC_W   = 16;
  localparam int FILT_W   = MV_W + FRAC_W;
  localparam int PROD_A_W = ALPHA_W + MV_W;
  localparam int PROD_B_W = ALPHA_W + FILT_W;
  localparam int NUM_W    = MV_W + PCT_W;
  localparam int STEP_W   = (PCT_W > 1) ? $clog2(PCT_W) : 1;

  localparam int RING_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SCAN_W  = $clog2(HISTORY_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = ALPHA_W;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GATE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_PREFILL = CFG_IDX_W'(3);

  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = ALPHA_W'(1311);
  localparam logic [MV_W-1:0]    GATE_RESET    = MV_W'(300);
  localparam logic [MV_W-1:0]    BYPASS_RESET  = MV_W'(1000);
  localparam logic [MV_W-1:0]    PREFILL_RESET = MV_W'(5000);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [MV_W-1:0]    MAG_MAX   = '1;
  localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);

  // Discharge curve, highest voltage first.
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    15'd14600, 15'd13600, 15'd13500, 15'd13400,
    15'd13300, 15'd13250, 15'd13200, 15'd13150,
    15'd13100, 15'd13050, 15'd13000, 15'd12900,
    15'd12800, 15'd12500, 15'd12000, 15'd11000
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd100, 7'd99, 7'd95,
    7'd90,  7'd80,  7'd70, 7'd60,
    7'd50,  7'd40,  7'd30, 7'd20,
    7'd15,  7'd10,  7'd5,  7'd0
  };

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_UPDATE,
    OP_HOLD
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [MV_W-1:0] raw;
    logic            due;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [MV_W-1:0]    gate;
    logic [MV_W-1:0]    bypass;
    logic [MV_W-1:0]    prefill;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WRITE,
    ST_SCAN,
    ST_SEG,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/bce_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bce_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 100,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/bce_front.sv @@
// Front end: takes input items, forms the current magnitude and classifies the filter step.
`default_nettype none

module bce_front import bce_pkg::*; (
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [MV_W-1:0]        bus_mv_i,
  input  logic signed [CUR_W-1:0] current_ma_i,
  input  logic                   history_due_i,
  input  cfg_t                   cfg_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output item_t                  push_item_o
);

  logic [CUR_W-1:0] cur_u;
  logic [CUR_W-1:0] neg_u;
  logic [CUR_W-1:0] mag_full;
  logic [MV_W-1:0]  mag;

  assign cur_u    = $unsigned(current_ma_i);
  assign neg_u    = ~cur_u + 1'b1;
  assign mag_full = cur_u[CUR_W-1] ? neg_u : cur_u;
  // Only the most negative current leaves the top bit set; it saturates.
  assign mag      = mag_full[CUR_W-1] ? MAG_MAX : mag_full[MV_W-1:0];

  always_comb begin
    push_item_o.raw = bus_mv_i;
    push_item_o.due = history_due_i;
    if (bus_mv_i < cfg_i.bypass) begin
      push_item_o.op = OP_LOAD;
    end else if (mag < cfg_i.gate) begin
      push_item_o.op = OP_UPDATE;
    end else begin
      push_item_o.op = OP_HOLD;
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

`default_nettype wire

@@ hw/rtl/bce_queue.sv @@
// Short queue of classified items between the front end and the back end.
`default_nettype none

module bce_queue import bce_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr_q, wptr_d;
  logic [QUEUE_AW-1:0]  rptr_q, rptr_d;
  logic [QUEUE_CW-1:0]  count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_item_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = ({1'b0, wptr_q} == (QUEUE_AW + 1)'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = ({1'b0, rptr_q} == (QUEUE_AW + 1)'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bce_back.sv @@
// Back end: filter update, history ring, peak scan, curve lookup and result register.
`default_nettype none

module bce_back import bce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  item_t            pop_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [MV_W-1:0]  filtered_mv_o,
  output logic [MV_W-1:0]  peak_mv_o,
  output logic [PCT_W-1:0] charge_percent_o
);

  state_e state_q, state_d;

  // Control state
  logic                     first_q, first_d;
  logic [FILT_W-1:0]        filter_q, filter_d;
  logic [RING_AW-1:0]       widx_q, widx_d;
  logic [HISTORY_DEPTH-1:0] valid_q, valid_d;
  logic [MV_W-1:0]          fill_q, fill_d;
  logic [MV_W-1:0]          entry0_q, entry0_d;
  logic [SCAN_W-1:0]        scan_q, scan_d;
  logic                     pipe_q, pipe_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     out_valid_q, out_valid_d;

  // Payload
  item_t                    item_q, item_d;
  logic [PROD_A_W-1:0]      prod_a_q, prod_a_d;
  logic [PROD_B_W-1:0]      prod_b_q, prod_b_d;
  logic                     sel_valid_q, sel_valid_d;
  logic [MV_W-1:0]          peak_q, peak_d;
  logic [NUM_W-1:0]         rem_q, rem_d;
  logic [NUM_W-1:0]         den_q, den_d;
  logic [PCT_W-1:0]         quo_q, quo_d;
  logic [PCT_W-1:0]         base_q, base_d;
  logic [MV_W-1:0]          out_filt_q, out_filt_d;
  logic [MV_W-1:0]          out_peak_q, out_peak_d;
  logic [PCT_W-1:0]         out_pct_q, out_pct_d;

  // Datapath helpers
  logic [ALPHA_W-1:0]       alpha_sat;
  logic [ALPHA_W-1:0]       alpha_rest;
  logic [PROD_A_W-1:0]      filt_sum;
  logic [MV_W-1:0]          filt_mv;
  logic [RING_AW-1:0]       widx_use;
  logic [MV_W-1:0]          entry0_now;
  logic [MV_W-1:0]          scan_entry;
  logic                     seg_direct;
  logic [PCT_W-1:0]         seg_direct_pct;
  logic [MV_W-1:0]          seg_vh, seg_vl;
  logic [PCT_W-1:0]         seg_ph, seg_pl;
  logic [NUM_W-1:0]         seg_num;

  // Ring RAM
  logic                     ram_we;
  logic [RING_AW-1:0]       ram_waddr;
  logic [MV_W-1:0]          ram_wdata;
  logic                     ram_re;
  logic [RING_AW-1:0]       ram_raddr;
  logic [MV_W-1:0]          ram_rdata;

  bce_ram #(
    .WIDTH (MV_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign alpha_sat  = (cfg_i.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha;
  assign alpha_rest = ALPHA_ONE - alpha_sat;
  assign filt_sum   = prod_a_q + prod_b_q[PROD_B_W-1:FRAC_W];
  assign filt_mv    = filter_q[FILT_W-1:FRAC_W];
  assign widx_use   = ({1'b0, widx_q} >= (RING_AW + 1)'(HISTORY_DEPTH)) ? '0 : widx_q;
  assign entry0_now = (item_q.due && (widx_use == '0)) ? filt_mv : entry0_q;
  // Entries not written since reset or since a prefill read as the fill value.
  assign scan_entry = sel_valid_q ? ram_rdata : fill_q;

  // Curve segment for the current peak: the first one whose lower point it reaches.
  always_comb begin
    seg_direct     = 1'b0;
    seg_direct_pct = CURVE_PCT[0];
    seg_vh         = CURVE_MV[0];
    seg_vl         = CURVE_MV[1];
    seg_ph         = CURVE_PCT[0];
    seg_pl         = CURVE_PCT[1];
    if (peak_q >= CURVE_MV[0]) begin
      seg_direct     = 1'b1;
      seg_direct_pct = CURVE_PCT[0];
    end else if (peak_q <= CURVE_MV[CURVE_POINTS-1]) begin
      seg_direct     = 1'b1;
      seg_direct_pct = CURVE_PCT[CURVE_POINTS-1];
    end else begin
      for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
        if (peak_q >= CURVE_MV[i+1]) begin
          seg_vh = CURVE_MV[i];
          seg_vl = CURVE_MV[i+1];
          seg_ph = CURVE_PCT[i];
          seg_pl = CURVE_PCT[i+1];
        end
      end
    end
    seg_num = NUM_W'(peak_q - seg_vl) * NUM_W'(seg_ph - seg_pl);
  end

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pop_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_WRITE;
      ST_WRITE: state_d = ST_SCAN;
      ST_SCAN:  if (scan_q == SCAN_W'(HISTORY_DEPTH)) state_d = ST_SEG;
      ST_SEG:   state_d = seg_direct ? ST_DONE : ST_DIV;
      ST_DIV:   if (step_q == STEP_W'(PCT_W - 1)) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    first_d     = first_q;
    filter_d    = filter_q;
    widx_d      = widx_q;
    valid_d     = valid_q;
    fill_d      = fill_q;
    entry0_d    = entry0_q;
    scan_d      = scan_q;
    pipe_d      = 1'b0;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    prod_a_d    = prod_a_q;
    prod_b_d    = prod_b_q;
    sel_valid_d = sel_valid_q;
    peak_d      = peak_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    base_d      = base_q;
    out_filt_d  = out_filt_q;
    out_peak_d  = out_peak_q;
    out_pct_d   = out_pct_q;
    pop_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = widx_use;
    ram_wdata   = filt_mv;
    ram_re      = 1'b0;
    ram_raddr   = scan_q[RING_AW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          item_d = pop_item_i;
        end
      end
      ST_MUL: begin
        prod_a_d = PROD_A_W'(alpha_sat) * PROD_A_W'(item_q.raw);
        prod_b_d = PROD_B_W'(alpha_rest) * PROD_B_W'(filter_q);
      end
      ST_ADD: begin
        if (first_q || (item_q.op == OP_LOAD)) begin
          filter_d = {item_q.raw, {FRAC_W{1'b0}}};
          first_d  = 1'b0;
        end else if (item_q.op == OP_UPDATE) begin
          filter_d = filt_sum[FILT_W-1:0];
        end
      end
      ST_WRITE: begin
        if (item_q.due) begin
          ram_we            = 1'b1;
          valid_d[widx_use] = 1'b1;
          widx_d = ({1'b0, widx_use} == (RING_AW + 1)'(HISTORY_DEPTH - 1)) ?
                   '0 : widx_use + 1'b1;
          if (widx_use == '0) begin
            entry0_d = filt_mv;
          end
        end
        // Prefill of an empty ring: every entry takes the filtered value.
        if ((entry0_now == '0) && (filter_q > {cfg_i.prefill, {FRAC_W{1'b0}}})) begin
          valid_d  = '0;
          fill_d   = filt_mv;
          entry0_d = filt_mv;
        end
        scan_d = '0;
        peak_d = '0;
      end
      ST_SCAN: begin
        if (pipe_q && (scan_entry > peak_q)) begin
          peak_d = scan_entry;
        end
        if (scan_q != SCAN_W'(HISTORY_DEPTH)) begin
          ram_re      = 1'b1;
          sel_valid_d = valid_q[scan_q[RING_AW-1:0]];
          scan_d      = scan_q + 1'b1;
          pipe_d      = 1'b1;
        end
      end
      ST_SEG: begin
        rem_d  = seg_num;
        den_d  = NUM_W'(seg_vh - seg_vl) << (PCT_W - 1);
        quo_d  = '0;
        step_d = '0;
        base_d = seg_direct ? seg_direct_pct : seg_pl;
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle.
        if (rem_q >= den_q) begin
          rem_d = rem_q - den_q;
          quo_d = {quo_q[PCT_W-2:0], 1'b1};
        end else begin
          quo_d = {quo_q[PCT_W-2:0], 1'b0};
        end
        den_d  = den_q >> 1;
        step_d = step_q + 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_filt_d  = filt_mv;
          out_peak_d  = peak_q;
          out_pct_d   = base_q + quo_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      filter_q    <= '0;
      widx_q      <= '0;
      valid_q     <= '0;
      fill_q      <= '0;
      entry0_q    <= '0;
      scan_q      <= '0;
      pipe_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      filter_q    <= filter_d;
      widx_q      <= widx_d;
      valid_q     <= valid_d;
      fill_q      <= fill_d;
      entry0_q    <= entry0_d;
      scan_q      <= scan_d;
      pipe_q      <= pipe_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    prod_a_q    <= prod_a_d;
    prod_b_q    <= prod_b_d;
    sel_valid_q <= sel_valid_d;
    peak_q      <= peak_d;
    rem_q       <= rem_d;
    den_q       <= den_d;
    quo_q       <= quo_d;
    base_q      <= base_d;
    out_filt_q  <= out_filt_d;
    out_peak_q  <= out_peak_d;
    out_pct_q   <= out_pct_d;
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_mv_o    = out_filt_q;
  assign peak_mv_o        = out_peak_q;
  assign charge_percent_o = out_pct_q;

endmodule

`default_nettype wire

@@ hw/rtl/battery_charge_estimator.sv @@
// Top level of the battery charge estimator: configuration registers, front end, queue, back end.
// A result follows its item through the filter multiply and add, the ring write, the walk over
// the history RAM read port, which dominates, and the divider; the divider is skipped when the peak
// lies at or beyond either end of the discharge curve. The back end works on one item at a time.
// Reset clears the filter, the ring index and the per-entry valid bits, so the ring reads as zero
// at once; no clearing pass is needed and items are accepted from the first cycle after reset.
`default_nettype none

module battery_charge_estimator import bce_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input item channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [MV_W-1:0]         bus_mv_i,
  input  logic signed [CUR_W-1:0] current_ma_i,
  input  logic                    history_due_i,
  // Result item channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [MV_W-1:0]         filtered_mv_o,
  output logic [MV_W-1:0]         peak_mv_o,
  output logic [PCT_W-1:0]        charge_percent_o,
  // Configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i
);

  // Configuration registers. Writes must arrive only while the block is idle; the block does not
  // enforce this, and the front and back ends read them directly without any shadowing.
  cfg_t  cfg_q, cfg_d;
  logic  cfg_write;

  // Front end to queue, queue to back end.
  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  // Register decode; a write to an index beyond the list is simply dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        CFG_ALPHA:   cfg_d.alpha   = cfg_data_i;
        CFG_GATE:    cfg_d.gate    = cfg_data_i[MV_W-1:0];
        CFG_BYPASS:  cfg_d.bypass  = cfg_data_i[MV_W-1:0];
        CFG_PREFILL: cfg_d.prefill = cfg_data_i[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha   <= ALPHA_RESET;
      cfg_q.gate    <= GATE_RESET;
      cfg_q.bypass  <= BYPASS_RESET;
      cfg_q.prefill <= PREFILL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end forms the current magnitude and decides whether the item loads,
  // updates or holds the filter. It accepts an item whenever the queue has room.
  bce_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .bus_mv_i      (bus_mv_i),
    .current_ma_i  (current_ma_i),
    .history_due_i (history_due_i),
    .cfg_i         (cfg_q),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  // Two-entry queue, so that new items are taken while the back end is busy.
  bce_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // The back end runs one item at a time through the filter multiply, the ring
  // write and prefill, the peak walk and the curve interpolation, and holds the
  // finished result in an output register until it is taken.
  bce_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_item_i       (pop_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_mv_o    (filtered_mv_o),
    .peak_mv_o        (peak_mv_o),
    .charge_percent_o (charge_percent_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/bce_checker.sv @@
// Port-level checker of the battery charge estimator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module bce_checker import bce_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [MV_W-1:0]         filtered_mv_o,
  input logic [MV_W-1:0]         peak_mv_o,
  input logic [PCT_W-1:0]        charge_percent_o
);

  // A waiting result keeps its fields until it is taken.
  `BCE_ASSERT_HOLD(a_out_hold, out_valid_o && !out_ready_i, {out_valid_o, filtered_mv_o, peak_mv_o, charge_percent_o}, "result changed while stalled")

  // The percentage never exceeds a full battery.
  `BCE_ASSERT(a_pct_range, out_valid_o |-> charge_percent_o <= PCT_FULL, "percent above full")

  // A peak at or above the top curve point reads as full.
  `BCE_ASSERT(a_pct_top, out_valid_o && peak_mv_o >= CURVE_MV[0] |-> charge_percent_o == CURVE_PCT[0], "top of curve not full")

  // A peak at or below the bottom curve point reads as empty.
  `BCE_ASSERT(a_pct_floor, out_valid_o && peak_mv_o <= CURVE_MV[CURVE_POINTS-1] |-> charge_percent_o == CURVE_PCT[CURVE_POINTS-1], "bottom of curve not empty")

endmodule

bind battery_charge_estimator bce_checker u_checker (.*);

`default_nettype wire

@@ verif/tb_battery_charge_estimator.sv @@
// Self-checking testbench for the battery charge estimator: directed and random telemetry items.
`timescale 1ns / 1ps

module tb_battery_charge_estimator;
  import bce_pkg::*;

  // The watchdog sits well above the slowest legal run. That run is roughly 750 items, each at
  // the block's slowest time per item, plus the longest gaps on both sides, the long receiver
  // hold-off and the drains between phases.
  localparam int CYCLE_LIMIT  = 600_000;
  // This many cycles pass after the last result, so that a stray extra result is still seen.
  localparam int DRAIN_CYCLES = 150;
  localparam int RING_ENTRIES = 100;
  localparam int KNOTS        = 16;
  localparam int FULL_ALPHA   = 65536;

  // Discharge curve knots, highest voltage first. This is our own copy, so that a wrong
  // table in the package shows up as a mismatch.
  localparam int unsigned KNOT_MV [KNOTS] = '{
    14600, 13600, 13500, 13400, 13300, 13250, 13200, 13150,
    13100, 13050, 13000, 12900, 12800, 12500, 12000, 11000
  };
  localparam int unsigned KNOT_PCT [KNOTS] = '{
    100, 100, 99, 95, 90, 80, 70, 60,
    50, 40, 30, 20, 15, 10, 5, 0
  };

  typedef struct packed {
    logic [MV_W-1:0]  filt_mv;
    logic [MV_W-1:0]  peak_mv;
    logic [PCT_W-1:0] percent;
  } reading_t;

  // Pacing of one side of the handshake: never idle, idle now and then, or a random wait drawn for every item.
  typedef enum int {
    PACE_BURST,
    PACE_MIXED,
    PACE_SLOW
  } pace_e;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_ready_o;
  logic [MV_W-1:0]         bus_mv_i         = '0;
  logic signed [CUR_W-1:0] current_ma_i     = '0;
  logic                    history_due_i    = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i      = 1'b0;
  logic [MV_W-1:0]         filtered_mv_o;
  logic [MV_W-1:0]         peak_mv_o;
  logic [PCT_W-1:0]        charge_percent_o;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i       = '0;

  // The estimator's own view of the registers and of the block's state.
  logic [ALPHA_W-1:0]     est_alpha;
  logic [MV_W-1:0]        est_gate;
  logic [MV_W-1:0]        est_bypass;
  logic [MV_W-1:0]        est_prefill;
  logic [MV_W+FRAC_W-1:0] est_filter;
  logic                   est_first;
  logic [MV_W-1:0]        est_ring [RING_ENTRIES];
  int                     est_ring_idx;

  reading_t expected_readings [$];
  int       mismatches      = 0;
  int       results_seen    = 0;
  pace_e    tx_pace         = PACE_BURST;
  pace_e    rx_pace         = PACE_BURST;
  int       hold_off_cycles = 0;

  battery_charge_estimator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .bus_mv_i         (bus_mv_i),
    .current_ma_i     (current_ma_i),
    .history_due_i    (history_due_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_mv_o    (filtered_mv_o),
    .peak_mv_o        (peak_mv_o),
    .charge_percent_o (charge_percent_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Estimator
  // ---------------------------------------------------------------------------------------

  // This walks the curve from the top. The first segment that holds the voltage is
  // interpolated, and the result is truncated.
  function automatic int unsigned percent_at(input logic [MV_W-1:0] mv);
    int unsigned v, vh, vl, ph, pl;
    int k;
    v = mv;
    if (v >= KNOT_MV[0]) return KNOT_PCT[0];
    if (v <= KNOT_MV[KNOTS-1]) return KNOT_PCT[KNOTS-1];
    for (k = 0; k < KNOTS - 1; k++) begin
      vh = KNOT_MV[k];
      vl = KNOT_MV[k+1];
      ph = KNOT_PCT[k];
      pl = KNOT_PCT[k+1];
      if (v <= vh && v >= vl && vh > vl && ph >= pl)
        return pl + ((v - vl) * (ph - pl)) / (vh - vl);
    end
    return 0;
  endfunction

  // This advances the estimator by one accepted item and returns the reading that the block
  // must give for it.
  function automatic reading_t estimate_charge(input logic [MV_W-1:0] raw,
                                               input logic signed [CUR_W-1:0] ma,
                                               input logic due);
    logic [16:0]     mag;
    logic [63:0]     weight;
    logic [63:0]     acc;
    logic [MV_W-1:0] filt;
    logic [MV_W-1:0] peak;
    reading_t        r;

    // The magnitude of the current saturates, so that -32768 reads as 32767.
    mag = ma[CUR_W-1] ? 17'h10000 - {1'b0, ma} : {1'b0, ma};
    if (mag > 17'd32767) mag = 17'd32767;

    if (est_first || raw < est_bypass) begin
      est_filter = {raw, 16'h0000};
      est_first  = 1'b0;
    end else if (mag < {2'b00, est_gate}) begin
      // An alpha above one acts as one.
      weight     = (est_alpha > ALPHA_W'(FULL_ALPHA)) ? 64'(FULL_ALPHA) : 64'(est_alpha);
      acc        = weight * 64'({raw, 16'h0000})
                 + (64'(FULL_ALPHA) - weight) * 64'(est_filter);
      est_filter = acc[46:16];
    end
    filt = est_filter[MV_W+FRAC_W-1:FRAC_W];

    if (due) begin
      if (est_ring_idx >= RING_ENTRIES) est_ring_idx = 0;
      est_ring[est_ring_idx] = filt;
      est_ring_idx = (est_ring_idx + 1) % RING_ENTRIES;
    end

    // The prefill compares at full precision, fraction bits included.
    if (est_ring[0] == '0 && est_filter > {est_prefill, 16'h0000})
      foreach (est_ring[k]) est_ring[k] = filt;

    peak = '0;
    foreach (est_ring[k])
      if (est_ring[k] > peak) peak = est_ring[k];

    r.filt_mv = filt;
    r.peak_mv = peak;
    r.percent = PCT_W'(percent_at(peak));
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------------------

  function automatic int draw_wait(input pace_e pace);
    case (pace)
      PACE_BURST: return 0;
      PACE_MIXED: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 11)) : 0;
      default:    return $urandom_range(0, 11);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // This offers one item after a random gap and returns at the edge that accepts it. Valid
  // stays high when the next item follows at once, so that it is never lowered and raised in
  // the same step.
  task automatic send_reading(input logic [MV_W-1:0] mv, input logic signed [CUR_W-1:0] ma,
                              input logic due);
    int gap;
    gap = draw_wait(tx_pace);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    bus_mv_i      <= mv;
    current_ma_i  <= ma;
    history_due_i <= due;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(estimate_charge(mv, ma, due));
  endtask

  // This draws a random item. Most voltages lie on the discharge curve and half of the
  // currents fall near the gate, so that the filter really moves. The rest covers the
  // extremes and the full ranges.
  task automatic send_random_reading();
    logic [MV_W-1:0]         mv;
    logic signed [CUR_W-1:0] ma;
    int unsigned             pick, span;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       mv = $urandom_range(0, 1) ? '1 : '0;
      1:       mv = MV_W'($urandom_range(0, 32767));
      2: begin
        span = est_bypass;
        mv = (span < 3) ? MV_W'($urandom_range(0, 4))
                        : MV_W'($urandom_range(span - 2, (span > 32765) ? 32767 : span + 2));
      end
      default: mv = MV_W'($urandom_range(10500, 15000));
    endcase
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      span = $urandom_range(0, (est_gate < 15'd32767) ? est_gate + 1 : 32767);
      ma = CUR_W'(span);
      if ($urandom_range(0, 1) == 1) ma = -ma;
    end else if (pick < 8) begin
      ma = CUR_W'($urandom());
    end else if (pick == 8) begin
      ma = 16'sh8000;
    end else begin
      ma = 16'sh7fff;
    end
    send_reading(mv, ma, 1'($urandom_range(0, 1)));
  endtask

  // This lowers valid and waits until every expected result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALPHA:   est_alpha   = value;
      CFG_GATE:    est_gate    = value[MV_W-1:0];
      CFG_BYPASS:  est_bypass  = value[MV_W-1:0];
      CFG_PREFILL: est_prefill = value[MV_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only while the block is idle, so the pipeline is drained first.
  task automatic apply_settings(input int unsigned alpha, input int unsigned gate,
                                input int unsigned bypass, input int unsigned prefill);
    settle();
    write_reg(CFG_ALPHA, CFG_DATA_W'(alpha));
    write_reg(CFG_GATE, CFG_DATA_W'(gate));
    write_reg(CFG_BYPASS, CFG_DATA_W'(bypass));
    write_reg(CFG_PREFILL, CFG_DATA_W'(prefill));
  endtask

  function automatic int unsigned pick_level(input int unsigned typical_hi);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 32767;
      2:       return $urandom_range(0, 32767);
      default: return $urandom_range(0, typical_hi);
    endcase
  endfunction

  function automatic int unsigned pick_alpha();
    case ($urandom_range(0, 6))
      0:       return 0;
      1:       return FULL_ALPHA;
      2:       return 131071;
      3:       return $urandom_range(0, 131071);
      default: return $urandom_range(100, 20000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // These items run under the register values that reset leaves. The first sample loads the
  // filter directly and prefills the empty ring. Then come the gate and bypass boundaries,
  // the saturated current magnitude and the extremes of both fields.
  task automatic test_reset_settings();
    tx_pace = PACE_BURST;
    rx_pace = PACE_MIXED;
    send_reading(15'd13550, 16'sd0, 1'b0);
    send_reading(15'd32767, 16'sd0, 1'b1);
    send_reading(15'd32767, -16'sd32768, 1'b1);
    send_reading(15'd0, 16'sd32767, 1'b1);
    send_reading(15'd20000, -16'sd1, 1'b0);
    send_reading(15'd20000, 16'sd299, 1'b1);
    send_reading(15'd20000, 16'sd300, 1'b0);
    send_reading(15'd20000, -16'sd299, 1'b0);
    send_reading(15'd20000, -16'sd300, 1'b0);
    send_reading(15'd999, 16'sd0, 1'b1);
    send_reading(15'd1000, 16'sd0, 1'b0);
    send_reading(15'd14600, 16'sd0, 1'b1);
    send_reading(15'd11000, 16'sd0, 1'b1);
  endtask

  // Each register is taken to its extremes. These include an alpha above one, a gate that
  // never opens, a bypass that catches nearly everything, and an alpha of zero that freezes
  // the filter.
  task automatic test_register_extremes();
    tx_pace = PACE_SLOW;
    rx_pace = PACE_SLOW;
    apply_settings(FULL_ALPHA, 32767, 0, 32767);
    send_reading(15'd14600, 16'sd0, 1'b1);
    send_reading(15'd0, -16'sd32767, 1'b1);
    send_reading(15'd32767, 16'sd32766, 1'b0);
    send_reading(15'd12000, -16'sd32768, 1'b1);
    apply_settings(131071, 0, 32767, 0);
    send_reading(15'd32767, 16'sd0, 1'b1);
    send_reading(15'd32766, 16'sd0, 1'b1);
    send_reading(15'd13000, 16'sd5, 1'b0);
    apply_settings(0, 32767, 0, 0);
    send_reading(15'd5, 16'sd0, 1'b1);
    send_reading(15'd32767, 16'sd100, 1'b1);
  endtask

  // This empties entry 0 of the ring again by writing zeros until the write pointer has just
  // passed it. Then it checks that the prefill compares at full precision. A filter value of
  // exactly the level does not prefill, but one fraction bit above it does.
  task automatic test_prefill_rearm();
    tx_pace = PACE_MIXED;
    rx_pace = PACE_BURST;
    apply_settings(FULL_ALPHA, 32767, 1000, 5000);
    do send_reading('0, CUR_W'($urandom()), 1'b1); while (est_ring_idx != 1);
    send_reading(15'd5000, 16'sd0, 1'b0);
    apply_settings(1, 32767, 1000, 5000);
    send_reading(15'd5001, 16'sd0, 1'b0);
    send_reading(15'd5001, 16'sd0, 1'b1);
  endtask

  // This is a slow random walk down from a full battery. Nearly every item is stored, so the
  // window peak trails the voltage and passes through every segment of the curve.
  task automatic test_discharge_sweep();
    int level, n;
    tx_pace = PACE_MIXED;
    rx_pace = PACE_MIXED;
    apply_settings(FULL_ALPHA, 32767, 1000, 32767);
    level = 14800;
    for (n = 0; n < 240; n++) begin
      send_reading(MV_W'(level), CUR_W'($urandom()), $urandom_range(0, 7) != 0);
      level = level - int'($urandom_range(0, 50));
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering items, so the
  // block fills up and stops accepting. Afterwards the sender waits for every result.
  task automatic test_backpressure();
    int n;
    settle();
    tx_pace = PACE_BURST;
    rx_pace = PACE_MIXED;
    hold_off_cycles = 2500;
    for (n = 0; n < 16; n++) send_random_reading();
    settle();
  endtask

  // These are random phases, each with its own register settings and its own mix of pacing
  // on the two sides.
  task automatic test_random_traffic();
    int p, n;
    for (p = 0; p < 6; p++) begin
      tx_pace = pace_e'(p % 3);
      rx_pace = pace_e'((p + p / 3) % 3);
      if (p == 0)
        apply_settings(1311, 300, 1000, 5000);
      else
        apply_settings(pick_alpha(), pick_level(2000), pick_level(3000), pick_level(15000));
      for (n = 0; n < 62; n++) send_random_reading();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------------------

  // For each result the receiver draws a stall. A pending hold-off request replaces the
  // draw, and it also interrupts a wait in which nothing is arriving.
  initial begin
    int stall;
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = draw_wait(rx_pace);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && hold_off_cycles == 0);
    end
  end

  // Each accepted result is compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected (filtered %0d)",
                                  results_seen, filtered_mv_o));
      end else begin
        want = expected_readings.pop_front();
        if (filtered_mv_o !== want.filt_mv)
          report_mismatch($sformatf("result %0d filtered_mv: got %0d, expected %0d",
                                    results_seen, filtered_mv_o, want.filt_mv));
        if (peak_mv_o !== want.peak_mv)
          report_mismatch($sformatf("result %0d peak_mv: got %0d, expected %0d",
                                    results_seen, peak_mv_o, want.peak_mv));
        if (charge_percent_o !== want.percent)
          report_mismatch($sformatf("result %0d charge_percent: got %0d, expected %0d",
                                    results_seen, charge_percent_o, want.percent));
      end
      results_seen++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, expected_readings.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    est_alpha    = 17'd1311;
    est_gate     = 15'd300;
    est_bypass   = 15'd1000;
    est_prefill  = 15'd5000;
    est_filter   = '0;
    est_first    = 1'b1;
    est_ring_idx = 0;
    foreach (est_ring[k]) est_ring[k] = '0;

    // Reset is held low at the start and released at a clock edge. The block needs no
    // clearing pass, so items follow at once.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_settings();
    test_register_extremes();
    test_prefill_rearm();
    test_discharge_sweep();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
